>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Request codes, character constants and the command record that travels
// from the front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Request codes as they arrive on the request channel.
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Character and attribute constants.
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_BLANK   = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	// Number of entries in the command queue between front and back end.
	localparam int QUEUE_DEPTH = 4;

	// One classified request.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [6:0] col;
		logic [4:0] row;
		logic       in_range;
		logic       newline;
	} cmd_t;

endpackage

>>> rtl/tcw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface tcw_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic [6:0] col;
	logic [4:0] row;

	modport source (output valid, output req_type, output char_code, output col,
		output row, input ready);
	modport sink (input valid, input req_type, input char_code, input col,
		input row, output ready);
endinterface

interface tcw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic       read_ok;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;

	modport source (output valid, output cell_char, output read_ok,
		output cursor_col, output cursor_row, input ready);
	modport sink (input valid, input cell_char, input read_ok,
		input cursor_col, input cursor_row, output ready);
endinterface

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console of ROWS x COLS cells with a cursor, scrolling and
// clear, fed by a request channel and answering on a response channel.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (valid/ready); one beat is one request: put
// character, set cursor, clear screen or read cell. Every request returns
// exactly one beat on rsp with the cursor position after the request, and
// for a read the cell's character with read_ok.
// The attribute register is written through cfg_we/cfg_wdata; the user
// is to write it only while the block is idle, which the block does not
// enforce. It is stored with every character and blank written.
// A request is registered in the command queue and then in the response
// register; a cell read also passes the registered screen memory read.
// Puts, cursor moves and out-of-range reads are taken one request per cycle
// while rsp is not stalled. A clear and a scroll sweep the screen memory
// through its single write port, a cell a cycle, and hold later requests.
// Reset: the screen memory is blanked by a sweep over every cell; the
// queue fills with up to four requests during it, then req waits.
// When rsp is stalled, the finished response holds in its register and
// requests keep entering the four-entry queue until it is full.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp
);

	logic push;
	logic full;
	logic pop;
	logic nonempty;
	cmd_t front_cmd;
	cmd_t queue_cmd;

	// Front end: accept and classify.
	tcw_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.req (req),
		.full(full),
		.push(push),
		.cmd (front_cmd)
	);

	// Command queue.
	tcw_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(front_cmd),
		.full    (full),
		.pop     (pop),
		.pop_cmd (queue_cmd),
		.nonempty(nonempty)
	);

	// Back end: execute against the screen and cursor.
	tcw_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(nonempty),
		.cmd      (queue_cmd),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts request beats and classifies them: newline detection and the
// screen range check of the requested cell.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	tcw_req_if.sink req,
	input  logic    full,
	output logic    push,
	output cmd_t    cmd
);

	// A beat is taken whenever the command queue has room.
	assign req.ready = !full;
	assign push      = req.valid && !full;

	// Classify the request.
	always_comb begin
		cmd.op       = req.req_type;
		cmd.ch       = req.char_code;
		cmd.col      = req.col;
		cmd.row      = req.row;
		cmd.in_range = (32'(req.col) < COLS) && (32'(req.row) < ROWS);
		cmd.newline  = (req.char_code == CH_NEWLINE);
	end

endmodule

>>> rtl/tcw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcw_fifo import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic nonempty
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [QW-1:0]   wptr_q;
	logic [QW-1:0]   rptr_q;
	logic [QW:0]     cnt_q;

	assign full     = (cnt_q == (QW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_cmd  = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QW+1)'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - (QW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer back end
// Executes queued commands against the screen memory and the cursor:
// character writes, cursor moves, cell reads, clear and scroll sweeps.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      pop,
	tcw_rsp_if.source rsp
);

	localparam int N  = ROWS * COLS;
	localparam int AW = $clog2(N);
	localparam int PW = $clog2(N + 1);
	localparam int XW = $clog2(COLS + 1);
	localparam int YW = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_FILL   = 3'd3;
	localparam logic [2:0] S_PUT    = 3'd4;

	typedef struct packed {
		logic [7:0] cell_char;
		logic       read_ok;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
	} rsp_t;

	logic [2:0]    state_q;
	logic [PW-1:0] ptr_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [7:0]    attr_q;
	logic [7:0]    ch_q;
	logic          owe_q;
	logic          put_q;
	logic          wr_s1;
	logic [AW-1:0] waddr_s1;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          slot_free;
	logic          last_row;
	logic          wrap;
	logic [YW-1:0] y_inc;
	logic          put_direct;
	logic [AW-1:0] put_addr;
	logic [AW-1:0] cmd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;
	logic          attr_skip;

	function automatic rsp_t make_rsp(logic [7:0] ch, logic ok, logic [XW-1:0] x,
		logic [YW-1:0] y);
		rsp_t r;
		r.cell_char  = ch;
		r.read_ok    = ok;
		r.cursor_col = 7'(x);
		r.cursor_row = 5'(y);
		return r;
	endfunction

	// Response channel.
	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_char  = rsp_q.cell_char;
	assign rsp.read_ok    = rsp_q.read_ok;
	assign rsp.cursor_col = rsp_q.cursor_col;
	assign rsp.cursor_row = rsp_q.cursor_row;

	// A command is taken only when its response will find the output slot free.
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign pop       = (state_q == S_IDLE) && cmd_valid && slot_free;

	// Cursor helpers.
	assign last_row = (y_q == YW'(ROWS - 1));
	assign wrap     = (x_q == XW'(COLS));
	assign y_inc    = y_q + YW'(1);

	// Addresses of a plain character write and of a requested cell.
	assign put_addr = wrap ? AW'(32'(y_inc) * COLS) : AW'(32'(y_q) * COLS + 32'(x_q));
	assign cmd_addr = AW'(32'(cmd.row) * COLS + 32'(cmd.col));
	assign put_direct = pop && (cmd.op == REQ_PUT) && !cmd.newline && !(wrap && last_row);

	// Attribute writes with two equal, nonzero nibbles are dropped.
	assign attr_skip = (cfg_wdata[7:4] == cfg_wdata[3:0]) && (cfg_wdata != 8'h00);

	// Screen memory write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = put_addr;
		wr_data = {attr_q, cmd.ch};
		case (state_q)
			S_IDLE: begin
				wr_en = put_direct;
			end
			S_SCROLL: begin
				wr_en   = wr_s1;
				wr_addr = waddr_s1;
				wr_data = rd_data;
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				wr_data = {attr_q, CH_BLANK};
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = AW'((ROWS - 1) * COLS);
				wr_data = {attr_q, ch_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Screen memory read port: cell reads, or the source row of a scroll.
	always_comb begin
		if (state_q == S_SCROLL) begin
			rd_en   = (ptr_q != PW'(N));
			rd_addr = ptr_q[AW-1:0];
		end else begin
			rd_en   = pop && (cmd.op == REQ_READ) && cmd.in_range;
			rd_addr = cmd_addr;
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(N)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Response payload register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					case (cmd.op)
						REQ_PUT: begin
							if (cmd.newline) begin
								rsp_q <= make_rsp(8'h00, 1'b0, '0, y_inc);
							end else if (!wrap) begin
								rsp_q <= make_rsp(8'h00, 1'b0, x_q + XW'(1), y_q);
							end else begin
								rsp_q <= make_rsp(8'h00, 1'b0, XW'(1), y_inc);
							end
						end
						REQ_SET: begin
							if (cmd.in_range) begin
								rsp_q <= make_rsp(8'h00, 1'b0, XW'(cmd.col), YW'(cmd.row));
							end else begin
								rsp_q <= make_rsp(8'h00, 1'b0, x_q, y_q);
							end
						end
						default: begin
							rsp_q <= make_rsp(8'h00, 1'b0, x_q, y_q);
						end
					endcase
				end
			end
			S_READ: begin
				rsp_q <= make_rsp(rd_data[7:0], 1'b1, x_q, y_q);
			end
			S_PUT: begin
				rsp_q <= make_rsp(8'h00, 1'b0, XW'(1), y_q);
			end
			default: begin
				rsp_q <= make_rsp(8'h00, 1'b0, x_q, y_q);
			end
		endcase
	end

	// Scroll pipeline: address of the row-above cell for the data being read.
	always_ff @(posedge clk) begin
		waddr_s1 <= AW'(ptr_q - PW'(COLS));
	end

	// Sequencer, cursor, attribute and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			ptr_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			ch_q        <= '0;
			owe_q       <= 1'b0;
			put_q       <= 1'b0;
			wr_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			attr_q      <= ATTR_RESET;
		end else begin
			if (cfg_we && !attr_skip) begin
				attr_q <= cfg_wdata;
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (cmd.op)
							REQ_PUT: begin
								if (cmd.newline) begin
									x_q <= '0;
									if (last_row) begin
										state_q <= S_SCROLL;
										ptr_q   <= PW'(COLS);
										owe_q   <= 1'b1;
										put_q   <= 1'b0;
									end else begin
										y_q         <= y_inc;
										rsp_valid_q <= 1'b1;
									end
								end else if (!wrap) begin
									x_q         <= x_q + XW'(1);
									rsp_valid_q <= 1'b1;
								end else if (!last_row) begin
									x_q         <= XW'(1);
									y_q         <= y_inc;
									rsp_valid_q <= 1'b1;
								end else begin
									// Wrap on the bottom row: scroll, then store the character.
									x_q     <= '0;
									ch_q    <= cmd.ch;
									state_q <= S_SCROLL;
									ptr_q   <= PW'(COLS);
									owe_q   <= 1'b1;
									put_q   <= 1'b1;
								end
							end
							REQ_SET: begin
								if (cmd.in_range) begin
									x_q <= XW'(cmd.col);
									y_q <= YW'(cmd.row);
								end
								rsp_valid_q <= 1'b1;
							end
							REQ_CLEAR: begin
								x_q     <= '0;
								y_q     <= '0;
								ptr_q   <= '0;
								owe_q   <= 1'b1;
								put_q   <= 1'b0;
								state_q <= S_FILL;
							end
							default: begin
								if (cmd.in_range) begin
									state_q <= S_READ;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_READ: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCROLL: begin
					// Copy every row one up, a cell per cycle; then blank the bottom row.
					if (ptr_q != PW'(N)) begin
						ptr_q <= ptr_q + PW'(1);
						wr_s1 <= 1'b1;
					end else begin
						wr_s1   <= 1'b0;
						ptr_q   <= PW'((ROWS - 1) * COLS);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (ptr_q == PW'(N - 1)) begin
						if (put_q) begin
							state_q <= S_PUT;
						end else begin
							state_q     <= S_IDLE;
							rsp_valid_q <= owe_q;
						end
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_PUT: begin
					x_q         <= XW'(1);
					put_q       <= 1'b0;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the response channel of the console writer and is bound to it.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_cell_char,
	input logic       rsp_read_ok,
	input logic [6:0] rsp_cursor_col,
	input logic [4:0] rsp_cursor_row
);

	// A stalled response beat stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// The cursor row never leaves the screen.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_cursor_row) < ROWS))
		else $error("cursor row outside the screen");

	// The cursor column is at most one past the last column.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_cursor_col) <= COLS))
		else $error("cursor column beyond the wrap position");

	// Only a valid read carries a character.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_read_ok |-> (rsp_cell_char == 8'h00))
		else $error("character returned without a valid read");

endmodule

bind text_console_writer tcw_checker #(
	.COLS(COLS),
	.ROWS(ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_cell_char (rsp.cell_char),
	.rsp_read_ok   (rsp.read_ok),
	.rsp_cursor_col(rsp.cursor_col),
	.rsp_cursor_row(rsp.cursor_row)
);

>>> tb/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, set-cursor, clear and read requests into the console over the
// valid/ready request channel and checks every response beat against a
// cycle-free model of the screen, the cursor and the attribute register.
// Directed requests cover the wrap, scroll and out-of-range cases. Random
// text runs, read-backs and noise follow, under three idling profiles and
// one long response stall.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int PHASE_ITEMS = 500;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic [6:0] col;
		logic [4:0] row;
	} request_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic       read_ok;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
	} response_t;

	// Screen and cursor model, plus the queue of responses still owed.
	class console_scoreboard;
		logic [15:0] cells [ROWS*COLS];
		int unsigned cur_x;
		int unsigned cur_y;
		logic [7:0]  text_attr;
		response_t   owed [$];
		int          mismatches;
		int          checked;
		int          scrolls;
		int          kind_count [4];

		function new();
			text_attr = ATTR_RESET;
			fill_rows(0, ROWS);
			cur_x = 0;
			cur_y = 0;
			mismatches = 0;
			checked = 0;
			scrolls = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function void fill_rows(int first, int last);
			for (int i = first * COLS; i < last * COLS; i++) cells[i] = {text_attr, CH_BLANK};
		endfunction

		// Move down one row; past the bottom the screen scrolls up by one.
		function void advance_row();
			cur_y++;
			if (cur_y >= ROWS) begin
				for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
				fill_rows(ROWS - 1, ROWS);
				cur_y = ROWS - 1;
				scrolls++;
			end
		endfunction

		// Equal nonzero nibbles are rejected by the register.
		function void set_attribute(logic [7:0] v);
			if (!(v != 8'h00 && v[7:4] == v[3:0])) text_attr = v;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_request(request_t r);
			response_t e;
			e = '0;
			kind_count[r.kind]++;
			case (r.kind)
			REQ_PUT: begin
				if (r.ch == CH_NEWLINE) begin
					cur_x = 0;
					advance_row();
				end else begin
					if (cur_x >= COLS) begin
						cur_x = 0;
						advance_row();
					end
					cells[cur_y * COLS + cur_x] = {text_attr, r.ch};
					cur_x++;
				end
			end
			REQ_SET: begin
				if (r.col < COLS && r.row < ROWS) begin
					cur_x = r.col;
					cur_y = r.row;
				end
			end
			REQ_CLEAR: begin
				fill_rows(0, ROWS);
				cur_x = 0;
				cur_y = 0;
			end
			REQ_READ: begin
				if (r.col < COLS && r.row < ROWS) begin
					e.cell_char = cells[r.row * COLS + r.col][7:0];
					e.read_ok = 1'b1;
				end
			end
			endcase
			e.cursor_col = 7'(cur_x);
			e.cursor_row = 5'(cur_y);
			owed.push_back(e);
		endfunction

		function void check_response(response_t got);
			response_t e;
			bit bad;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("%0t: response with none owed: char %02h ok %0d col %0d row %0d",
						$realtime, got.cell_char, got.read_ok, got.cursor_col, got.cursor_row);
				return;
			end
			e = owed.pop_front();
			checked++;
			bad = (got.cell_char !== e.cell_char) || (got.read_ok !== e.read_ok) ||
				(got.cursor_col !== e.cursor_col) || (got.cursor_row !== e.cursor_row);
			if (bad) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("%0t: response %0d: expected char %02h ok %0d col %0d row %0d, %s%02h %0d %0d %0d",
						$realtime, checked, e.cell_char, e.read_ok, e.cursor_col, e.cursor_row,
						"got ", got.cell_char, got.read_ok, got.cursor_col, got.cursor_row);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	console_scoreboard board;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_request = 0;
	int requests_sent = 0;
	int attr_writes = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Response side: check each accepted beat, then pick ready for the next cycle.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_response('{rsp_ch.cell_char, rsp_ch.read_ok, rsp_ch.cursor_col,
					rsp_ch.cursor_row});
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request beat, idling first at the sender's rate, and hold it until accepted.
	task automatic send_request(request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.char_code <= r.ch;
		req_ch.col <= r.col;
		req_ch.row <= r.row;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(r);
		requests_sent++;
	endtask

	// Drop valid, wait for all responses, then let a full screen sweep finish.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (ROWS * COLS + 64) @(posedge clk);
	endtask

	task automatic write_attribute(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_attribute(v);
		attr_writes++;
		@(posedge clk);
	endtask

	// Put, set or read with random content; coordinates mostly on screen unless wide is set.
	function automatic request_t random_request(bit wide);
		request_t r;
		int pick;
		r.ch = ($urandom_range(7) == 0) ? CH_NEWLINE : 8'($urandom_range(255));
		r.col = 7'($urandom_range(127));
		r.row = 5'($urandom_range(31));
		if (!wide && $urandom_range(3) != 0) begin
			r.col = 7'($urandom_range(COLS - 1));
			r.row = 5'($urandom_range(ROWS - 1));
		end
		pick = $urandom_range(99);
		r.kind = (pick < 45) ? REQ_PUT : (pick < 65) ? REQ_SET : REQ_READ;
		return r;
	endfunction

	// Place the cursor, type a burst of text, then read back what landed.
	task automatic run_text_line();
		int n;
		logic [6:0] c;
		logic [4:0] r;
		r = ($urandom_range(2) == 0) ? 5'(ROWS - 1) : 5'($urandom_range(ROWS - 1));
		c = $urandom_range(1) ? 7'($urandom_range(COLS - 1, COLS - 20))
			: 7'($urandom_range(COLS - 1));
		send_request('{REQ_SET, 8'($urandom), c, r});
		n = $urandom_range(24, 3);
		repeat (n)
			send_request('{REQ_PUT, ($urandom_range(11) == 0) ? CH_NEWLINE : 8'($urandom),
				7'($urandom), 5'($urandom)});
		c = (board.cur_x > 0) ? 7'(board.cur_x - 1) : 7'd0;
		send_request('{REQ_READ, 8'($urandom), c, 5'(board.cur_y)});
		send_request('{REQ_READ, 8'($urandom), 7'($urandom_range(COLS - 1)), 5'(board.cur_y)});
	endtask

	task automatic run_random(int target);
		int start;
		int pick;
		start = requests_sent;
		while (requests_sent - start < target) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_request(random_request(1'b0));
			end else if (pick < 75) begin
				run_text_line();
			end else if (pick < 92) begin
				repeat (4)
					send_request('{REQ_READ, 8'($urandom), 7'($urandom_range(COLS - 1)),
						5'($urandom_range(ROWS - 1))});
			end else if (pick < 97) begin
				repeat (3) send_request(random_request(1'b1));
			end else begin
				send_request('{REQ_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom)});
			end
		end
	endtask

	// Field extremes, wrap and newline on the last row, out-of-range cursor and reads, clear.
	task automatic run_directed();
		send_request('{REQ_READ, 8'h00, 7'd0, 5'd0});
		send_request('{REQ_PUT, 8'h41, 7'd127, 5'd31});
		send_request('{REQ_PUT, 8'h00, 7'd0, 5'd0});
		send_request('{REQ_PUT, 8'hFF, 7'd0, 5'd0});
		send_request('{REQ_READ, 8'hFF, 7'd0, 5'd0});
		send_request('{REQ_READ, 8'h00, 7'd1, 5'd0});
		send_request('{REQ_READ, 8'h00, 7'd2, 5'd0});
		send_request('{REQ_SET, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1)});
		send_request('{REQ_PUT, 8'h78, 7'd0, 5'd0});
		send_request('{REQ_PUT, 8'h79, 7'd0, 5'd0});
		send_request('{REQ_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 2)});
		send_request('{REQ_READ, 8'h00, 7'd0, 5'(ROWS - 1)});
		send_request('{REQ_PUT, CH_NEWLINE, 7'd0, 5'd0});
		send_request('{REQ_READ, 8'h00, 7'd0, 5'(ROWS - 2)});
		send_request('{REQ_SET, 8'h00, 7'(COLS), 5'd0});
		send_request('{REQ_SET, 8'h00, 7'd0, 5'(ROWS)});
		send_request('{REQ_SET, 8'h00, 7'd127, 5'd31});
		send_request('{REQ_READ, 8'h00, 7'(COLS), 5'd0});
		send_request('{REQ_READ, 8'h00, 7'd0, 5'(ROWS)});
		send_request('{REQ_READ, 8'h00, 7'd127, 5'd31});
		send_request('{REQ_SET, 8'h00, 7'd0, 5'd0});
		send_request('{REQ_PUT, CH_NEWLINE, 7'd0, 5'd0});
		send_request('{REQ_CLEAR, 8'hFF, 7'd127, 5'd31});
		send_request('{REQ_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)});
	endtask

	// Main sequence: reset, directed checks, then three random phases.
	initial begin
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_PUT;
		req_ch.char_code <= 8'h00;
		req_ch.col <= 7'd0;
		req_ch.row <= 5'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();
		write_attribute(8'hFF);
		run_directed();
		for (int phase = 0; phase < 3; phase++) begin
			wait_idle();
			case (phase)
			0: begin
				write_attribute(8'h00);
				send_idle_pct = 21;
				recv_idle_pct = 53;
			end
			1: begin
				write_attribute(8'h11);
				write_attribute(8'hA5);
				send_idle_pct = 53;
				recv_idle_pct = 21;
			end
			default: begin
				write_attribute(8'hF0);
				write_attribute(8'($urandom_range(255)));
				send_idle_pct = 0;
				recv_idle_pct = 0;
				stall_request = 400;
			end
			endcase
			run_random(PHASE_ITEMS);
		end
		wait_idle();
		$display("Ran %0d requests: %0d puts, %0d cursor sets, %0d clears, %0d reads.",
			requests_sent, board.kind_count[REQ_PUT], board.kind_count[REQ_SET],
			board.kind_count[REQ_CLEAR], board.kind_count[REQ_READ]);
		$display("Checked %0d responses across %0d scrolls and %0d attribute writes; %0d bad.",
			board.checked, board.scrolls, attr_writes, board.mismatches);
		if (board.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
